// ----- rtl/obot_pkg.sv -----
// Package: widths, pipeline types and CORDIC helpers for the box overlap test.
`timescale 1ns / 1ps
package obot_pkg;

   localparam int CW    = 20;        // coordinate width, signed Q12.8
   localparam int SW    = CW - 1;    // size width, unsigned Q11.8
   localparam int AW    = 16;        // binary angle width
   localparam int STEPS = 16;        // CORDIC iterations
   localparam int SPS   = 4;         // CORDIC iterations per pipeline stage
   localparam int CSTG  = STEPS / SPS;
   localparam int XW    = 20;        // CORDIC x/y width, signed Q16
   localparam int ZW    = 34;        // CORDIC residual angle width
   localparam int DW    = CW + 1;    // centre difference width
   localparam int PW    = DW + 21;   // doubled corner offset before rounding
   localparam int RW    = PW - 16;   // rounded corner offset
   localparam int LW    = RW + XW + 2; // frame-rotated corner
   localparam int QW    = 2 * SW;    // squared size
   localparam int DQW   = 2 * DW;    // squared distance

   localparam logic signed [XW-1:0] CORDIC_START = XW'(39797);
   localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'h40000000);
   localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'h80000000);

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 flip;
   } cord_type;

   // side data carried down the pipe with each item
   typedef struct packed {
      logic signed [DW-1:0] dx;      // first minus second
      logic signed [DW-1:0] dy;
      logic [1:0][SW-1:0]   len;
      logic [1:0][SW-1:0]   wid;
      logic                 pass;    // coarse test result
   } carry_type;

   function automatic logic signed [ZW-1:0] arc(input int i);
      logic [31:0] v;
      case (i)
         0:       v = 32'h20000000;
         1:       v = 32'h12E4051E;
         2:       v = 32'h09FB385B;
         3:       v = 32'h051111D4;
         4:       v = 32'h028B0D43;
         5:       v = 32'h0145D7E1;
         6:       v = 32'h00A2F61E;
         7:       v = 32'h00517C55;
         8:       v = 32'h0028BE53;
         9:       v = 32'h00145F2F;
         10:      v = 32'h000A2F98;
         11:      v = 32'h000517CC;
         12:      v = 32'h00028BE6;
         13:      v = 32'h000145F3;
         14:      v = 32'h0000A2F9;
         15:      v = 32'h0000517C;
         default: v = 32'h0;
      endcase
      return signed'({{(ZW-32){1'b0}}, v});
   endfunction

   function automatic cord_type cordic_step(input cord_type c, input int i);
      cord_type             r;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      xs = c.x >>> i;
      ys = c.y >>> i;
      r  = c;
      if (c.z >= 0) begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - arc(i);
      end else begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + arc(i);
      end
      return r;
   endfunction

   // widen the angle to a 32-bit turn and fold into +-quarter turn
   function automatic cord_type cordic_init(input logic [AW-1:0] ang);
      cord_type             r;
      logic [31:0]          a;
      logic signed [ZW-1:0] z;
      a = {ang, {(32-AW){1'b0}}};
      z = ZW'(signed'(a));
      r.x = CORDIC_START;
      r.y = '0;
      r.flip = 1'b0;
      if (z > QUARTER_TURN) begin
         z = z - HALF_TURN;
         r.flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z = z + HALF_TURN;
         r.flip = 1'b1;
      end
      r.z = z;
      return r;
   endfunction

endpackage

// ----- rtl/obot_if.sv -----
// Channel interfaces: box pair requests and hit responses.
`timescale 1ns / 1ps
interface obot_req_if;
   logic                           valid;
   logic                           ready;
   logic signed [obot_pkg::CW-1:0] first_x;
   logic signed [obot_pkg::CW-1:0] first_y;
   logic [obot_pkg::AW-1:0]        first_angle;
   logic [obot_pkg::SW-1:0]        first_width;
   logic [obot_pkg::SW-1:0]        first_length;
   logic signed [obot_pkg::CW-1:0] second_x;
   logic signed [obot_pkg::CW-1:0] second_y;
   logic [obot_pkg::AW-1:0]        second_angle;
   logic [obot_pkg::SW-1:0]        second_width;
   logic [obot_pkg::SW-1:0]        second_length;

   modport source (output valid, first_x, first_y, first_angle, first_width, first_length,
                   second_x, second_y, second_angle, second_width, second_length,
                   input ready);
   modport sink   (input valid, first_x, first_y, first_angle, first_width, first_length,
                   second_x, second_y, second_angle, second_width, second_length,
                   output ready);
endinterface

interface obot_rsp_if;
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink   (input valid, hit, output ready);
endinterface

// ----- rtl/oriented_box_overlap_test_top.sv -----
// Oriented box overlap test: 10-stage pipeline, CORDIC sin/cos and corner checks.
// Throughput: one item per cycle; the whole pipe holds only while the response
// register is full and not taken (req ready = !rsp valid || rsp ready).
// CORDIC runs 4 iterations per stage over 4 stages; the 8 corners are checked in parallel.
// Reset (synchronous, active high) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps
module oriented_box_overlap_test_top (
   input  logic        clock,
   input  logic        reset,
   obot_req_if.sink    req_ch,
   obot_rsp_if.source  rsp_ch
);

   localparam int NSTG = 10;

   logic                 adv;
   logic [NSTG:1]        valid_ff;

   // stage 1
   obot_pkg::carry_type  car1_ff;
   obot_pkg::cord_type   cord_ff [0:obot_pkg::CSTG][2];
   logic [3:0][obot_pkg::QW-1:0]  szsq_ff;
   logic [1:0][obot_pkg::DQW-1:0] dsq_ff;
   logic [obot_pkg::DW-1:0]       adx_in, ady_in;
   logic signed [obot_pkg::DW-1:0] dx_in, dy_in;
   // stage 2
   obot_pkg::carry_type  car2_ff;
   logic [obot_pkg::QW+1:0]  szsum_ff;
   logic [obot_pkg::DQW:0]   dsum_ff;
   // stages 3..5 carry
   obot_pkg::carry_type  car3_ff, car4_ff, car5_ff;
   obot_pkg::carry_type  car3_in;
   // stage 6
   obot_pkg::carry_type  car6_ff;
   logic signed [obot_pkg::XW-1:0] cos_ff [2];
   logic signed [obot_pkg::XW-1:0] sin_ff [2];
   // stage 7
   obot_pkg::carry_type  car7_ff;
   logic signed [obot_pkg::XW-1:0] cos7_ff [2];
   logic signed [obot_pkg::XW-1:0] sin7_ff [2];
   logic signed [2*obot_pkg::XW-1:0] cl_ff [2];
   logic signed [2*obot_pkg::XW-1:0] sl_ff [2];
   logic signed [2*obot_pkg::XW-1:0] cw_ff [2];
   logic signed [2*obot_pkg::XW-1:0] sw_ff [2];
   // stage 8
   obot_pkg::carry_type  car8_ff;
   logic signed [obot_pkg::XW-1:0] cos8_ff [2];
   logic signed [obot_pkg::XW-1:0] sin8_ff [2];
   logic signed [obot_pkg::RW-1:0] pr_ff [8];
   logic signed [obot_pkg::RW-1:0] qr_ff [8];
   logic signed [obot_pkg::RW-1:0] pr_in [8];
   logic signed [obot_pkg::RW-1:0] qr_in [8];
   // stage 9
   obot_pkg::carry_type  car9_ff;
   logic signed [obot_pkg::LW-1:0] along_ff [8];
   logic signed [obot_pkg::LW-1:0] across_ff [8];
   logic signed [obot_pkg::LW-1:0] along_in [8];
   logic signed [obot_pkg::LW-1:0] across_in [8];
   // stage 10
   logic                 hit_ff;
   logic                 hit_in;

   assign adv          = !valid_ff[NSTG] || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign rsp_ch.valid = valid_ff[NSTG];
   assign rsp_ch.hit   = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NSTG-1:1], req_ch.valid};
      end
   end

   // stage 1: fold angles, centre differences, squares for the coarse test
   always_comb begin
      dx_in  = obot_pkg::DW'(req_ch.first_x) - obot_pkg::DW'(req_ch.second_x);
      dy_in  = obot_pkg::DW'(req_ch.first_y) - obot_pkg::DW'(req_ch.second_y);
      adx_in = dx_in[obot_pkg::DW-1] ? obot_pkg::DW'(-dx_in) : obot_pkg::DW'(dx_in);
      ady_in = dy_in[obot_pkg::DW-1] ? obot_pkg::DW'(-dy_in) : obot_pkg::DW'(dy_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car1_ff.dx     <= dx_in;
         car1_ff.dy     <= dy_in;
         car1_ff.len[0] <= req_ch.first_length;
         car1_ff.len[1] <= req_ch.second_length;
         car1_ff.wid[0] <= req_ch.first_width;
         car1_ff.wid[1] <= req_ch.second_width;
         car1_ff.pass   <= 1'b0;
         cord_ff[0][0]  <= obot_pkg::cordic_init(req_ch.first_angle);
         cord_ff[0][1]  <= obot_pkg::cordic_init(req_ch.second_angle);
         szsq_ff[0]     <= req_ch.first_width * req_ch.first_width;
         szsq_ff[1]     <= req_ch.first_length * req_ch.first_length;
         szsq_ff[2]     <= req_ch.second_width * req_ch.second_width;
         szsq_ff[3]     <= req_ch.second_length * req_ch.second_length;
         dsq_ff[0]      <= adx_in * adx_in;
         dsq_ff[1]      <= ady_in * ady_in;
      end
   end

   // CORDIC stages 2..5, four iterations each
   for (genvar g = 0; g < obot_pkg::CSTG; g++) begin : g_cordic
      obot_pkg::cord_type nxt [2];
      always_comb begin
         for (int b = 0; b < 2; b++) begin
            nxt[b] = cord_ff[g][b];
            for (int m = 0; m < obot_pkg::SPS; m++) begin
               nxt[b] = obot_pkg::cordic_step(nxt[b], g * obot_pkg::SPS + m);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cord_ff[g+1][0] <= nxt[0];
            cord_ff[g+1][1] <= nxt[1];
         end
      end
   end

   // coarse test: sums in stage 2, compare in stage 3
   always_comb begin
      car3_in      = car2_ff;
      car3_in.pass = (obot_pkg::DQW+2)'(szsum_ff) > {dsum_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car2_ff  <= car1_ff;
         szsum_ff <= (obot_pkg::QW+2)'(szsq_ff[0]) + (obot_pkg::QW+2)'(szsq_ff[1])
                   + (obot_pkg::QW+2)'(szsq_ff[2]) + (obot_pkg::QW+2)'(szsq_ff[3]);
         dsum_ff  <= (obot_pkg::DQW+1)'(dsq_ff[0]) + (obot_pkg::DQW+1)'(dsq_ff[1]);
         car3_ff  <= car3_in;
         car4_ff  <= car3_ff;
         car5_ff  <= car4_ff;
      end
   end

   // stage 6: undo the fold
   always_ff @(posedge clock) begin
      if (adv) begin
         car6_ff <= car5_ff;
         for (int b = 0; b < 2; b++) begin
            cos_ff[b] <= cord_ff[obot_pkg::CSTG][b].flip ? -cord_ff[obot_pkg::CSTG][b].x
                                                         :  cord_ff[obot_pkg::CSTG][b].x;
            sin_ff[b] <= cord_ff[obot_pkg::CSTG][b].flip ? -cord_ff[obot_pkg::CSTG][b].y
                                                         :  cord_ff[obot_pkg::CSTG][b].y;
         end
      end
   end

   // stage 7: rotate the half sizes (kept doubled) of each box
   always_ff @(posedge clock) begin
      if (adv) begin
         car7_ff <= car6_ff;
         for (int b = 0; b < 2; b++) begin
            cos7_ff[b] <= cos_ff[b];
            sin7_ff[b] <= sin_ff[b];
            cl_ff[b] <= cos_ff[b] * signed'({1'b0, car6_ff.len[b]});
            sl_ff[b] <= sin_ff[b] * signed'({1'b0, car6_ff.len[b]});
            cw_ff[b] <= cos_ff[b] * signed'({1'b0, car6_ff.wid[b]});
            sw_ff[b] <= sin_ff[b] * signed'({1'b0, car6_ff.wid[b]});
         end
      end
   end

   // stage 8: corner offsets from the other centre, rounded to doubled Q.8
   always_comb begin
      logic signed [obot_pkg::PW-1:0] dxp, dyp, p, q, ta, tb, tc, td;
      for (int n = 0; n < 8; n++) begin
         dxp = (n >= 4) ? -(obot_pkg::PW'(car7_ff.dx) <<< 17) : (obot_pkg::PW'(car7_ff.dx) <<< 17);
         dyp = (n >= 4) ? -(obot_pkg::PW'(car7_ff.dy) <<< 17) : (obot_pkg::PW'(car7_ff.dy) <<< 17);
         ta  = obot_pkg::PW'(cl_ff[n/4]);
         tb  = obot_pkg::PW'(sw_ff[n/4]);
         tc  = obot_pkg::PW'(sl_ff[n/4]);
         td  = obot_pkg::PW'(cw_ff[n/4]);
         p   = dxp + ((n & 2) != 0 ? -ta : ta) - ((n & 1) != 0 ? -tb : tb);
         q   = dyp + ((n & 2) != 0 ? -tc : tc) + ((n & 1) != 0 ? -td : td);
         p   = (p + obot_pkg::PW'(32768)) >>> 16;
         q   = (q + obot_pkg::PW'(32768)) >>> 16;
         pr_in[n] = obot_pkg::RW'(p);
         qr_in[n] = obot_pkg::RW'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car8_ff <= car7_ff;
         cos8_ff <= cos7_ff;
         sin8_ff <= sin7_ff;
         pr_ff   <= pr_in;
         qr_ff   <= qr_in;
      end
   end

   // stage 9: into the other box's frame (rotate through minus its angle)
   always_comb begin
      for (int n = 0; n < 8; n++) begin
         along_in[n]  = obot_pkg::LW'(pr_ff[n] * cos8_ff[1 - n/4])
                      + obot_pkg::LW'(qr_ff[n] * sin8_ff[1 - n/4]);
         across_in[n] = obot_pkg::LW'(qr_ff[n] * cos8_ff[1 - n/4])
                      - obot_pkg::LW'(pr_ff[n] * sin8_ff[1 - n/4]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car9_ff   <= car8_ff;
         along_ff  <= along_in;
         across_ff <= across_in;
      end
   end

   // stage 10: strict inside test, any corner hits, gated by the coarse test
   always_comb begin
      logic signed [obot_pkg::LW-1:0] lim_l, lim_w;
      hit_in = 1'b0;
      for (int n = 0; n < 8; n++) begin
         lim_l = obot_pkg::LW'({car9_ff.len[1 - n/4], 16'h0000});
         lim_w = obot_pkg::LW'({car9_ff.wid[1 - n/4], 16'h0000});
         if (-lim_l < along_ff[n] && along_ff[n] < lim_l &&
             -lim_w < across_ff[n] && across_ff[n] < lim_w) begin
            hit_in = 1'b1;
         end
      end
      hit_in = hit_in & car9_ff.pass;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
      end
   end

endmodule

// ----- rtl/obot_check.sv -----
// Port-level checker for the box overlap test, bound to the top level.
`timescale 1ns / 1ps
module obot_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled response changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipe stalled");

endmodule

bind oriented_box_overlap_test_top obot_check u_obot_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_hit   (rsp_ch.hit)
);

// ----- tb/oriented_box_overlap_test_top_tb.sv -----
// Testbench for the oriented box overlap test: predicted hit per box pair, checked in order.
`timescale 1ns / 1ps
module oriented_box_overlap_test_top_tb;

   typedef struct {
      logic signed [obot_pkg::CW-1:0] x, y;
      logic [obot_pkg::AW-1:0]        ang;
      logic [obot_pkg::SW-1:0]        wid, len;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fails = 0;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   bit   hit_queue[$];

   obot_req_if req_ch ();
   obot_rsp_if rsp_ch ();

   oriented_box_overlap_test_top u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // sine and cosine in Q16, folded rotation CORDIC
   function automatic void trig(input logic [obot_pkg::AW-1:0] ang, output longint c,
                                output longint s);
      longint a, z, x, y, nx;
      bit     flip;
      longint arcs[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                           64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                           64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                           64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
      a = longint'(ang) << (32 - obot_pkg::AW);
      z = (a >= 64'h80000000) ? a - 64'h100000000 : a;
      x = 39797;
      y = 0;
      flip = 0;
      if (z > 64'sh40000000) begin
         z -= 64'h80000000;
         flip = 1;
      end else if (z < -64'sh40000000) begin
         z += 64'h80000000;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y  = y + floor_shift(x, i);
            z -= arcs[i];
         end else begin
            nx = x + floor_shift(y, i);
            y  = y - floor_shift(x, i);
            z += arcs[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic bit overlap_hit(box_type bx[2]);
      longint    cx[2], sn[2], px[2], py[2], ln[2], wd[2];
      longint    p, q, pr, qr, along, across, sl, sw, dx, dy;
      bit [127:0] sq, dsq;
      for (int b = 0; b < 2; b++) begin
         px[b] = bx[b].x;
         py[b] = bx[b].y;
         ln[b] = bx[b].len;
         wd[b] = bx[b].wid;
         trig(bx[b].ang, cx[b], sn[b]);
      end
      sq = ln[0] * ln[0] + wd[0] * wd[0] + ln[1] * ln[1] + wd[1] * wd[1];
      dx = px[0] - px[1];
      dy = py[0] - py[1];
      dsq = 2 * (dx * dx + dy * dy);
      if (sq <= dsq) return 0;
      for (int b = 0; b < 2; b++) begin
         for (int j = 0; j < 4; j++) begin
            sl = j[0] ? -ln[b] : ln[b];
            sw = j[1] ? -wd[b] : wd[b];
            p  = (px[b] - px[1-b]) * 131072 + cx[b] * sl - sn[b] * sw;
            q  = (py[b] - py[1-b]) * 131072 + sn[b] * sl + cx[b] * sw;
            pr = floor_shift(p + 32768, 16);
            qr = floor_shift(q + 32768, 16);
            along  = pr * cx[1-b] + qr * sn[1-b];
            across = qr * cx[1-b] - pr * sn[1-b];
            if (-ln[1-b] * 65536 < along && along < ln[1-b] * 65536 &&
                -wd[1-b] * 65536 < across && across < wd[1-b] * 65536)
               return 1;
         end
      end
      return 0;
   endfunction

   task automatic send_pair(box_type bx[2]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.first_x      <= bx[0].x;
      req_ch.first_y      <= bx[0].y;
      req_ch.first_angle  <= bx[0].ang;
      req_ch.first_width  <= bx[0].wid;
      req_ch.first_length <= bx[0].len;
      req_ch.second_x      <= bx[1].x;
      req_ch.second_y      <= bx[1].y;
      req_ch.second_angle  <= bx[1].ang;
      req_ch.second_width  <= bx[1].wid;
      req_ch.second_length <= bx[1].len;
      do @(posedge clock); while (!req_ch.ready);
      hit_queue.push_back(overlap_hit(bx));
      @(negedge clock);
   endtask

   always @(negedge clock) rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (hit_queue.size() == 0) begin
            $error("hit: expected none, actual %0d", rsp_ch.hit);
            fails++;
         end else begin
            bit want;
            want = hit_queue.pop_front();
            if (rsp_ch.hit !== want) begin
               $error("hit: expected %0d, actual %0d", want, rsp_ch.hit);
               fails++;
            end
         end
      end
   end

   function automatic box_type near_box(logic signed [obot_pkg::CW-1:0] cx,
                                        logic signed [obot_pkg::CW-1:0] cy,
                                        int spread, int maxsize);
      box_type r;
      r.x   = obot_pkg::CW'(int'(cx) + int'($urandom_range(2 * spread)) - spread);
      r.y   = obot_pkg::CW'(int'(cy) + int'($urandom_range(2 * spread)) - spread);
      r.ang = obot_pkg::AW'($urandom);
      r.wid = obot_pkg::SW'($urandom_range(maxsize));
      r.len = obot_pkg::SW'($urandom_range(maxsize));
      return r;
   endfunction

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (hit_queue.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      box_type bx[2];
      box_type a;
      a = '{x: 0, y: 0, ang: 0, wid: 512, len: 1024};
      bx = '{a, a};
      send_pair(bx);                                   // identical boxes
      bx[1].ang = 16'h4000; send_pair(bx);             // crossed
      bx[1].ang = 16'h8000; send_pair(bx);
      bx[1].ang = 16'hFFFF; send_pair(bx);
      bx[1].ang = 16'hC000; send_pair(bx);
      bx[1] = a; bx[1].wid = 0; send_pair(bx);         // zero width
      bx[1] = a; bx[1].len = 0; bx[1].wid = 100; send_pair(bx);
      bx[0].wid = 0; bx[0].len = 0; bx[1].wid = 0; send_pair(bx);
      // corner exactly on an edge: unrotated boxes touching
      bx[0] = '{x: 0, y: 0, ang: 0, wid: 512, len: 512};
      bx[1] = '{x: 512, y: 512, ang: 0, wid: 512, len: 512};
      send_pair(bx);
      bx[1].x = 511; bx[1].y = 511; send_pair(bx);
      // coarse test equal: sizes^2 sum = 2*dist^2
      bx[0] = '{x: 0, y: 0, ang: 0, wid: 2, len: 0};
      bx[1] = '{x: 2, y: 0, ang: 0, wid: 2, len: 0};
      send_pair(bx);
      // field extremes
      bx[0] = '{x: 20'sh7FFFF, y: 20'sh80000, ang: 16'hFFFF, wid: 19'h7FFFF, len: 19'h7FFFF};
      bx[1] = '{x: 20'sh80000, y: 20'sh7FFFF, ang: 0, wid: 19'h7FFFF, len: 19'h7FFFF};
      send_pair(bx);
      bx[1] = bx[0]; send_pair(bx);
      bx[0].x = 20'sh80000; bx[1].x = 20'sh80000; bx[0].ang = 16'h2000; send_pair(bx);
      bx[0] = '{x: -1, y: -1, ang: 16'h8000, wid: 19'h40000, len: 1};
      bx[1] = '{x: 20'sh7FFFF, y: 0, ang: 16'h0001, wid: 1, len: 19'h40000};
      send_pair(bx);
      drain();
   endtask

   task automatic test_random(int count);
      box_type bx[2];
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(3))
            0: begin
               bx[0] = near_box(obot_pkg::CW'($urandom), obot_pkg::CW'($urandom), 0, 19'h7FFFF);
               bx[1] = near_box(obot_pkg::CW'($urandom), obot_pkg::CW'($urandom), 0, 19'h7FFFF);
               bx[0].wid = obot_pkg::SW'($urandom);
               bx[0].len = obot_pkg::SW'($urandom);
            end
            default: begin
               bx[0] = near_box(obot_pkg::CW'($urandom), obot_pkg::CW'($urandom), 0, 4096);
               bx[1] = near_box(bx[0].x, bx[0].y, 3000, 4096);
            end
         endcase
         send_pair(bx);
      end
   endtask

   task automatic test_hold_off();
      test_random(20);
      drain();
      repeat (15) @(negedge clock);
      test_random(20);
      drain();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.first_x = '0; req_ch.first_y = '0; req_ch.first_angle = '0;
      req_ch.first_width = '0; req_ch.first_length = '0;
      req_ch.second_x = '0; req_ch.second_y = '0; req_ch.second_angle = '0;
      req_ch.second_width = '0; req_ch.second_length = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(245);
      send_idle_pct = 63; test_random(200);
      send_idle_pct = 0;  stall_pct = 63; test_random(200);
      send_idle_pct = 36; stall_pct = 36; test_random(150);
      send_idle_pct = 0;  stall_pct = 0;  test_hold_off();
      drain();
      repeat (20) @(negedge clock);
      if (fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/obot_pkg.sv
rtl/obot_if.sv
rtl/oriented_box_overlap_test_top.sv
rtl/obot_check.sv
tb/oriented_box_overlap_test_top_tb.sv
